// File: sv/sbps_pkg.sv
// shared constants and types for the soft body point integrator
package sbps_pkg;

    localparam int MAX_POINTS  = 1024;
    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;

    localparam int ADDR_W    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int IDX_W     = 10;
    localparam int IO_W      = 32;
    localparam int FIN_W     = 17;
    localparam int FRAC_W    = FRAC_BITS + 1;
    localparam int DIFF_W    = COORD_WIDTH + 1;
    localparam int SUM_W     = COORD_WIDTH + 2;
    localparam int WIDE_W    = COORD_WIDTH + IO_W;
    localparam int NSTG      = 8;
    localparam int NAX       = 3;
    localparam int CFG_IDX_W = 2;

    localparam logic [FRAC_W-1:0] FRAC_ONE = {1'b1, {FRAC_BITS{1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STIFFNESS = CFG_IDX_W'(0),
        CFG_DAMPING   = CFG_IDX_W'(1)
    } t_cfg_idx;

    typedef enum logic {
        OP_INIT = 1'b0,
        OP_STEP = 1'b1
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [IDX_W-1:0]  idx;
        logic              in_rng;
        logic [FRAC_W-1:0] g;
        logic [FRAC_W-1:0] gi;
    } t_ctl;

    // per axis working set, fields reused from stage to stage
    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] rest;
        logic signed [COORD_WIDTH-1:0] pos;
        logic signed [COORD_WIDTH-1:0] vel;
        logic [DIFF_W-1:0]             amag;
        logic                          aneg;
        logic [COORD_WIDTH-1:0]        bmag;
        logic                          bneg;
        logic signed [SUM_W-1:0]       frc;
    } t_ax;

endpackage

// File: sv/sbps_ram.sv
// generic single port write, single port read ram with registered read
module sbps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/soft_body_point_step.sv
// soft body point integrator: damped spring step per point, state in two rams
//
// Input channel i_valid / o_stall carries one item: opcode, point index, rest
// position and goal weight. An init item places the point at rest with zero
// velocity; a step item pulls toward rest, applies spring force and damping
// and moves the point. Every item gives one result on o_valid / i_stall: the
// point index and its new position (zero for an index beyond the store).
// Config port i_cfg_valid / o_cfg_ready writes spring stiffness (index 0) and
// damping (index 1); write it only while no item is in flight.
// Throughput is one item per cycle for distinct points while results are not
// stalled. An item passes the eight stage read, multiply, add, write back
// pipeline around the position and velocity rams, then the output register,
// on its way to o_valid. An item for a point that is still in the pipeline
// is held on o_stall until that point has been written back.
// While i_stall holds a result, the pipeline keeps filling its empty stages
// and keeps accepting items until it is full.
// Synchronous reset empties the pipeline and sets stiffness and damping to zero;
// ram contents are undefined until an init item writes a point.
module soft_body_point_step (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic                                   i_opcode,
    input  logic [sbps_pkg::IDX_W-1:0]             i_point_index,
    input  logic signed [sbps_pkg::IO_W-1:0]       i_rest_x,
    input  logic signed [sbps_pkg::IO_W-1:0]       i_rest_y,
    input  logic signed [sbps_pkg::IO_W-1:0]       i_rest_z,
    input  logic [sbps_pkg::FIN_W-1:0]             i_goal_weight,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic [sbps_pkg::IDX_W-1:0]             o_point_out,
    output logic signed [sbps_pkg::IO_W-1:0]       o_pos_x,
    output logic signed [sbps_pkg::IO_W-1:0]       o_pos_y,
    output logic signed [sbps_pkg::IO_W-1:0]       o_pos_z,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [sbps_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [sbps_pkg::FIN_W-1:0]             i_cfg_data
);

    localparam int CW   = sbps_pkg::COORD_WIDTH;
    localparam int NSTG = sbps_pkg::NSTG;
    localparam int NAX  = sbps_pkg::NAX;
    localparam int RW   = NAX * CW;

    // ---------------------------------------------------------------- helpers

    function automatic logic signed [CW-1:0] sat_wide(
        input logic signed [sbps_pkg::WIDE_W-1:0] w
    );
        logic [sbps_pkg::WIDE_W-CW:0] hi_bits;
        hi_bits = w[sbps_pkg::WIDE_W-1:CW-1];
        if (hi_bits == '0 || hi_bits == '1) begin
            return w[CW-1:0];
        end else if (w[sbps_pkg::WIDE_W-1]) begin
            return {1'b1, {(CW-1){1'b0}}};
        end else begin
            return {1'b0, {(CW-1){1'b1}}};
        end
    endfunction

    function automatic logic [sbps_pkg::FRAC_W-1:0] clamp_frac(
        input logic [sbps_pkg::FIN_W-1:0] f
    );
        logic [sbps_pkg::FIN_W+sbps_pkg::FRAC_W-1:0] w;
        w = (sbps_pkg::FIN_W + sbps_pkg::FRAC_W)'(f);
        if (w > (sbps_pkg::FIN_W + sbps_pkg::FRAC_W)'(sbps_pkg::FRAC_ONE)) begin
            return sbps_pkg::FRAC_ONE;
        end else begin
            return w[sbps_pkg::FRAC_W-1:0];
        end
    endfunction

    function automatic logic [sbps_pkg::DIFF_W-1:0] mag_d(
        input logic signed [sbps_pkg::DIFF_W-1:0] d
    );
        logic [sbps_pkg::DIFF_W-1:0] u;
        u = d;
        return d[sbps_pkg::DIFF_W-1] ? (~u + sbps_pkg::DIFF_W'(1)) : u;
    endfunction

    function automatic logic [CW-1:0] mag_c(input logic signed [CW-1:0] v);
        logic [CW-1:0] u;
        u = v;
        return v[CW-1] ? (~u + CW'(1)) : u;
    endfunction

    function automatic logic signed [sbps_pkg::SUM_W-1:0] apply_sign(
        input logic [sbps_pkg::DIFF_W-1:0] m,
        input logic                        neg
    );
        logic signed [sbps_pkg::SUM_W-1:0] s;
        s = sbps_pkg::SUM_W'(m);
        return neg ? -s : s;
    endfunction

    function automatic logic [sbps_pkg::IO_W-1:0] to_io(input logic signed [CW-1:0] p);
        logic signed [sbps_pkg::WIDE_W-1:0] w;
        w = sbps_pkg::WIDE_W'(p);
        return w[sbps_pkg::IO_W-1:0];
    endfunction

    // stage 1 and 4: distance to rest and velocity as sign and magnitude
    function automatic sbps_pkg::t_ax f_diff(input sbps_pkg::t_ax a);
        sbps_pkg::t_ax                     r;
        logic signed [sbps_pkg::DIFF_W-1:0] d;
        r = a;
        d = sbps_pkg::DIFF_W'(a.rest) - sbps_pkg::DIFF_W'(a.pos);
        r.aneg = d[sbps_pkg::DIFF_W-1];
        r.amag = mag_d(d);
        r.bneg = a.vel[CW-1];
        r.bmag = mag_c(a.vel);
        return r;
    endfunction

    // stage 2 and 5: magnitude times fraction, truncated
    function automatic sbps_pkg::t_ax f_mul(
        input sbps_pkg::t_ax               a,
        input logic [sbps_pkg::FRAC_W-1:0] fa,
        input logic [sbps_pkg::FRAC_W-1:0] fb
    );
        sbps_pkg::t_ax                                    r;
        logic [sbps_pkg::DIFF_W+sbps_pkg::FRAC_W-1:0]     pa;
        logic [CW+sbps_pkg::FRAC_W-1:0]                   pb;
        r  = a;
        pa = (sbps_pkg::DIFF_W + sbps_pkg::FRAC_W)'(a.amag)
           * (sbps_pkg::DIFF_W + sbps_pkg::FRAC_W)'(fa);
        pb = (CW + sbps_pkg::FRAC_W)'(a.bmag) * (CW + sbps_pkg::FRAC_W)'(fb);
        r.amag = pa[sbps_pkg::FRAC_BITS +: sbps_pkg::DIFF_W];
        r.bmag = pb[sbps_pkg::FRAC_BITS +: CW];
        return r;
    endfunction

    // stage 3: goal pull on position, goal scaled velocity
    function automatic sbps_pkg::t_ax f_goal(input sbps_pkg::t_ax a);
        sbps_pkg::t_ax                     r;
        logic signed [sbps_pkg::SUM_W-1:0] sa;
        logic signed [sbps_pkg::SUM_W-1:0] sb;
        r  = a;
        sa = apply_sign(a.amag, a.aneg);
        sb = apply_sign(sbps_pkg::DIFF_W'(a.bmag), a.bneg);
        r.pos = sat_wide(sbps_pkg::WIDE_W'(sbps_pkg::SUM_W'(a.pos) + sa));
        r.vel = sb[CW-1:0];
        return r;
    endfunction

    // stage 6: signed spring force and damped velocity
    function automatic sbps_pkg::t_ax f_sign(input sbps_pkg::t_ax a);
        sbps_pkg::t_ax                     r;
        logic signed [sbps_pkg::SUM_W-1:0] sb;
        r     = a;
        r.frc = apply_sign(a.amag, a.aneg);
        sb    = apply_sign(sbps_pkg::DIFF_W'(a.bmag), a.bneg);
        r.vel = sb[CW-1:0];
        return r;
    endfunction

    // stage 7: new velocity
    function automatic sbps_pkg::t_ax f_vel(input sbps_pkg::t_ax a);
        sbps_pkg::t_ax r;
        r     = a;
        r.vel = sat_wide(sbps_pkg::WIDE_W'(sbps_pkg::SUM_W'(a.vel) + a.frc));
        return r;
    endfunction

    // stage 8: new position, or the init values
    function automatic sbps_pkg::t_ax f_end(input sbps_pkg::t_ax a, input sbps_pkg::t_op op);
        sbps_pkg::t_ax r;
        r = a;
        if (op == sbps_pkg::OP_INIT) begin
            r.pos = a.rest;
            r.vel = '0;
        end else begin
            r.pos = sat_wide(sbps_pkg::WIDE_W'(sbps_pkg::SUM_W'(a.pos)
                                              + sbps_pkg::SUM_W'(a.vel)));
        end
        return r;
    endfunction

    // ---------------------------------------------------------------- state

    logic                          r_run;
    logic [NSTG:1]                 r_vld;
    logic                          r_ovld;
    logic [sbps_pkg::FRAC_W-1:0]   r_stiff;
    logic [sbps_pkg::FRAC_W-1:0]   r_dinv;

    sbps_pkg::t_ctl                r_ctl [1:NSTG];
    sbps_pkg::t_ax                 r_ax  [1:NSTG][0:NAX-1];
    logic [sbps_pkg::IDX_W-1:0]    r_out_idx;
    logic [sbps_pkg::IO_W-1:0]     r_out_pos [0:NAX-1];

    logic [NSTG+1:1]               rdy;
    logic                          hazard;
    logic                          accept;
    logic                          cfg_wr;
    sbps_pkg::t_ctl                n_ctl;
    sbps_pkg::t_ax                 n_ax1 [0:NAX-1];
    sbps_pkg::t_ax                 n_ax  [2:NSTG][0:NAX-1];
    sbps_pkg::t_ax                 fin_ax [0:NAX-1];
    logic signed [sbps_pkg::IO_W-1:0] rest_in [0:NAX-1];

    logic                          ram_we;
    logic                          ram_re;
    logic [sbps_pkg::ADDR_W-1:0]   ram_waddr;
    logic [sbps_pkg::ADDR_W-1:0]   ram_raddr;
    logic [RW-1:0]                 ram_pos_wd;
    logic [RW-1:0]                 ram_vel_wd;
    logic [RW-1:0]                 ram_pos_rd;
    logic [RW-1:0]                 ram_vel_rd;

    // ---------------------------------------------------------------- handshake

    always_comb begin
        rdy[NSTG+1] = !r_ovld || !i_stall;
        for (int s = NSTG; s >= 1; s--) begin
            rdy[s] = !r_vld[s] || rdy[s+1];
        end
    end

    // hold off an item whose point is still on its way to write back
    always_comb begin
        hazard = 1'b0;
        for (int s = 1; s <= NSTG; s++) begin
            if (r_vld[s] && r_ctl[s].idx == i_point_index) begin
                hazard = 1'b1;
            end
        end
    end

    assign o_stall     = !r_run || !i_rst_n || !rdy[1] || hazard;
    assign accept      = i_valid && !o_stall;
    assign o_cfg_ready = r_run && i_rst_n;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    // ---------------------------------------------------------------- datapath

    assign rest_in[0] = i_rest_x;
    assign rest_in[1] = i_rest_y;
    assign rest_in[2] = i_rest_z;

    always_comb begin
        n_ctl.op     = sbps_pkg::t_op'(i_opcode);
        n_ctl.idx    = i_point_index;
        n_ctl.in_rng = int'(i_point_index) < sbps_pkg::MAX_POINTS;
        n_ctl.g      = clamp_frac(i_goal_weight);
        n_ctl.gi     = sbps_pkg::FRAC_ONE - n_ctl.g;
    end

    always_comb begin
        for (int a = 0; a < NAX; a++) begin
            n_ax1[a]      = '0;
            n_ax1[a].rest = sat_wide(sbps_pkg::WIDE_W'(rest_in[a]));
        end
    end

    always_comb begin
        for (int a = 0; a < NAX; a++) begin
            n_ax[2][a]     = r_ax[1][a];
            n_ax[2][a].pos = ram_pos_rd[a*CW +: CW];
            n_ax[2][a].vel = ram_vel_rd[a*CW +: CW];
            n_ax[2][a]     = f_diff(n_ax[2][a]);
            n_ax[3][a]     = f_mul(r_ax[2][a], r_ctl[2].g, r_ctl[2].gi);
            n_ax[4][a]     = f_goal(r_ax[3][a]);
            n_ax[5][a]     = f_diff(r_ax[4][a]);
            n_ax[6][a]     = f_mul(r_ax[5][a], r_stiff, r_dinv);
            n_ax[7][a]     = f_sign(r_ax[6][a]);
            n_ax[8][a]     = f_vel(r_ax[7][a]);
            fin_ax[a]      = f_end(r_ax[NSTG][a], r_ctl[NSTG].op);
        end
    end

    always_comb begin
        for (int a = 0; a < NAX; a++) begin
            ram_pos_wd[a*CW +: CW] = fin_ax[a].pos;
            ram_vel_wd[a*CW +: CW] = fin_ax[a].vel;
        end
    end

    assign ram_re    = accept;
    assign ram_raddr = sbps_pkg::ADDR_W'(i_point_index);
    assign ram_we    = r_vld[NSTG] && rdy[NSTG+1] && r_ctl[NSTG].in_rng;
    assign ram_waddr = sbps_pkg::ADDR_W'(r_ctl[NSTG].idx);

    sbps_ram #(
        .WIDTH (RW),
        .DEPTH (sbps_pkg::MAX_POINTS)
    ) u_pos_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_pos_wd),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_pos_rd)
    );

    sbps_ram #(
        .WIDTH (RW),
        .DEPTH (sbps_pkg::MAX_POINTS)
    ) u_vel_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_vel_wd),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_vel_rd)
    );

    // ---------------------------------------------------------------- registers

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run   <= 1'b0;
            r_vld   <= '0;
            r_ovld  <= 1'b0;
            r_stiff <= '0;
            r_dinv  <= sbps_pkg::FRAC_ONE;
        end else begin
            r_run <= 1'b1;
            if (rdy[1]) begin
                r_vld[1] <= accept;
            end
            for (int s = 2; s <= NSTG; s++) begin
                if (rdy[s]) begin
                    r_vld[s] <= r_vld[s-1];
                end
            end
            if (rdy[NSTG+1]) begin
                r_ovld <= r_vld[NSTG];
            end
            if (cfg_wr) begin
                case (i_cfg_index)
                    sbps_pkg::CFG_STIFFNESS: begin
                        r_stiff <= clamp_frac(i_cfg_data);
                    end
                    sbps_pkg::CFG_DAMPING: begin
                        r_dinv <= sbps_pkg::FRAC_ONE - clamp_frac(i_cfg_data);
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ctl[1] <= n_ctl;
            for (int a = 0; a < NAX; a++) begin
                r_ax[1][a] <= n_ax1[a];
            end
        end
        for (int s = 2; s <= NSTG; s++) begin
            if (rdy[s] && r_vld[s-1]) begin
                r_ctl[s] <= r_ctl[s-1];
                for (int a = 0; a < NAX; a++) begin
                    r_ax[s][a] <= n_ax[s][a];
                end
            end
        end
        if (rdy[NSTG+1] && r_vld[NSTG]) begin
            r_out_idx <= r_ctl[NSTG].idx;
            for (int a = 0; a < NAX; a++) begin
                r_out_pos[a] <= r_ctl[NSTG].in_rng ? to_io(fin_ax[a].pos) : '0;
            end
        end
    end

    assign o_valid     = r_ovld;
    assign o_point_out = r_out_idx;
    assign o_pos_x     = r_out_pos[0];
    assign o_pos_y     = r_out_pos[1];
    assign o_pos_z     = r_out_pos[2];

endmodule

// File: sv/sbps_check.sv
// port level checker for the soft body point integrator, bound to the top level
module sbps_check (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_valid,
    input logic                              o_stall,
    input logic                              i_opcode,
    input logic [sbps_pkg::IDX_W-1:0]        i_point_index,
    input logic signed [sbps_pkg::IO_W-1:0]  i_rest_x,
    input logic signed [sbps_pkg::IO_W-1:0]  i_rest_y,
    input logic signed [sbps_pkg::IO_W-1:0]  i_rest_z,
    input logic [sbps_pkg::FIN_W-1:0]        i_goal_weight,
    input logic                              o_valid,
    input logic                              i_stall,
    input logic [sbps_pkg::IDX_W-1:0]        o_point_out,
    input logic signed [sbps_pkg::IO_W-1:0]  o_pos_x,
    input logic signed [sbps_pkg::IO_W-1:0]  o_pos_y,
    input logic signed [sbps_pkg::IO_W-1:0]  o_pos_z,
    input logic                              i_cfg_valid,
    input logic                              o_cfg_ready,
    input logic [sbps_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input logic [sbps_pkg::FIN_W-1:0]        i_cfg_data
);

    // a result waiting on the receiver stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    // and keeps its fields
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_point_out) && $stable(o_pos_x)
                               && $stable(o_pos_y) && $stable(o_pos_z))
        else $error("stalled result changed");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result offered right after reset");

    // a point just taken in cannot be read again before it is written back
    a_same_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) ##1 (i_valid && i_point_index == $past(i_point_index))
        |-> o_stall)
        else $error("back to back item on one point not held");

endmodule

bind soft_body_point_step sbps_check u_sbps_check (.*);

// File: verif/soft_body_point_step_chk.sv
`timescale 1ns / 100ps
// checker for the point integrator: predicts every result and compares it
module soft_body_point_step_chk (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic                               i_in_stall,
    input  logic                               i_opcode,
    input  logic [sbps_pkg::IDX_W-1:0]         i_point_index,
    input  logic signed [sbps_pkg::IO_W-1:0]   i_rest_x,
    input  logic signed [sbps_pkg::IO_W-1:0]   i_rest_y,
    input  logic signed [sbps_pkg::IO_W-1:0]   i_rest_z,
    input  logic [sbps_pkg::FIN_W-1:0]         i_goal_weight,
    input  logic                               i_out_valid,
    input  logic                               i_out_stall,
    input  logic [sbps_pkg::IDX_W-1:0]         i_point_out,
    input  logic signed [sbps_pkg::IO_W-1:0]   i_pos_x,
    input  logic signed [sbps_pkg::IO_W-1:0]   i_pos_y,
    input  logic signed [sbps_pkg::IO_W-1:0]   i_pos_z,
    input  logic                               i_cfg_valid,
    input  logic                               i_cfg_ready,
    input  logic [sbps_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [sbps_pkg::FIN_W-1:0]         i_cfg_data,
    output int                                 o_mismatches,
    output int                                 o_pending
);
    import sbps_pkg::*;

    localparam longint COORD_MAX = (longint'(1) << (COORD_WIDTH - 1)) - 1;
    localparam longint COORD_MIN = -COORD_MAX - 1;
    localparam longint UNITY     = longint'(1) << FRAC_BITS;

    typedef struct {
        logic [IDX_W-1:0] idx;
        logic [IO_W-1:0]  x;
        logic [IO_W-1:0]  y;
        logic [IO_W-1:0]  z;
    } t_position;

    typedef struct {
        longint p;
        longint v;
    } t_axis_state;

    t_position        expected_positions[$];
    longint           pos_mem [NAX][MAX_POINTS];
    longint           vel_mem [NAX][MAX_POINTS];
    logic [FIN_W-1:0] stiffness;
    logic [FIN_W-1:0] damping;
    int               mismatches;
    int               items_taken;
    int               results_seen;

    assign o_mismatches = mismatches;
    assign o_pending    = items_taken - results_seen;

    function automatic longint clip_coord(longint v);
        if (v > COORD_MAX) return COORD_MAX;
        if (v < COORD_MIN) return COORD_MIN;
        return v;
    endfunction

    function automatic longint cap_frac(longint f);
        return (f > UNITY) ? UNITY : f;
    endfunction

    // coordinate times fraction, truncated toward zero
    function automatic longint frac_mul(longint v, longint f);
        longint m;
        longint p;
        m = (v < 0) ? -v : v;
        p = (m >> FRAC_BITS) * f + (((m & (UNITY - 1)) * f) >> FRAC_BITS);
        return (v < 0) ? -p : p;
    endfunction

    // goal pull, spring force, damping and move for one axis
    function automatic t_axis_state advance_axis(longint rest, longint g, t_axis_state s);
        t_axis_state n;
        longint      spring;
        n.p    = clip_coord(s.p + frac_mul(rest - s.p, g));
        n.v    = frac_mul(s.v, UNITY - g);
        spring = frac_mul(rest - n.p, cap_frac(longint'(stiffness)));
        n.v    = clip_coord(frac_mul(n.v, UNITY - cap_frac(longint'(damping))) + spring);
        n.p    = clip_coord(n.p + n.v);
        return n;
    endfunction

    task automatic check_field(string field, logic [IO_W-1:0] want, logic [IO_W-1:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch on %s: expected %h, got %h", field, want, got);
            end
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_position        want;
        longint           rest_in [NAX];
        longint           g;
        t_axis_state      s;
        logic [IDX_W-1:0] idx;
        if (!i_rst_n) begin
            expected_positions.delete();
            stiffness    = '0;
            damping      = '0;
            mismatches   = 0;
            items_taken  <= 0;
            results_seen <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_STIFFNESS: stiffness = i_cfg_data;
                    CFG_DAMPING:   damping   = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                results_seen <= results_seen + 1;
                if (expected_positions.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("result for point %0d with no item outstanding", i_point_out);
                    end
                end else begin
                    want = expected_positions.pop_front();
                    check_field("point_out", IO_W'(want.idx), IO_W'(i_point_out));
                    check_field("pos_x", want.x, i_pos_x);
                    check_field("pos_y", want.y, i_pos_y);
                    check_field("pos_z", want.z, i_pos_z);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                items_taken <= items_taken + 1;
                rest_in[0] = longint'(i_rest_x);
                rest_in[1] = longint'(i_rest_y);
                rest_in[2] = longint'(i_rest_z);
                g   = cap_frac(longint'(i_goal_weight));
                idx = i_point_index;
                for (int a = 0; a < NAX; a++) begin
                    if (i_opcode == OP_INIT) begin
                        pos_mem[a][idx] = clip_coord(rest_in[a]);
                        vel_mem[a][idx] = 0;
                    end else begin
                        s.p = pos_mem[a][idx];
                        s.v = vel_mem[a][idx];
                        s   = advance_axis(rest_in[a], g, s);
                        pos_mem[a][idx] = s.p;
                        vel_mem[a][idx] = s.v;
                    end
                end
                expected_positions.push_back('{idx, IO_W'(pos_mem[0][idx]),
                                               IO_W'(pos_mem[1][idx]),
                                               IO_W'(pos_mem[2][idx])});
            end
        end
    end

endmodule

// File: verif/soft_body_point_step_tb.sv
`timescale 1ns / 100ps
// testbench top for the point integrator: stimulus, handshake pacing and verdict
module soft_body_point_step_tb;
    import sbps_pkg::*;

    localparam int NPHASES         = 6;
    localparam int ITEMS_PER_PHASE = 255;
    localparam int HOLD_CYCLES     = 150;
    localparam int SPAN            = 1000 << FRAC_BITS;
    localparam int NUDGE           = 4 << FRAC_BITS;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = CFG_IDX_W'(3);
    localparam logic [IO_W-1:0] WORD_MAX = 32'h7FFF_FFFF;
    localparam logic [IO_W-1:0] WORD_MIN = 32'h8000_0000;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_valid       = 1'b0;
    logic                   i_opcode      = 1'b0;
    logic [IDX_W-1:0]       i_point_index = '0;
    logic signed [IO_W-1:0] i_rest_x      = '0;
    logic signed [IO_W-1:0] i_rest_y      = '0;
    logic signed [IO_W-1:0] i_rest_z      = '0;
    logic [FIN_W-1:0]       i_goal_weight = '0;
    logic                   i_stall       = 1'b0;
    logic                   i_cfg_valid   = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index   = '0;
    logic [FIN_W-1:0]       i_cfg_data    = '0;
    logic                   o_stall;
    logic                   o_valid;
    logic [IDX_W-1:0]       o_point_out;
    logic signed [IO_W-1:0] o_pos_x;
    logic signed [IO_W-1:0] o_pos_y;
    logic signed [IO_W-1:0] o_pos_z;
    logic                   o_cfg_ready;

    int mismatches;
    int pending;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_req      = 0;
    int hold_seen     = 0;
    int hold_left     = 0;

    logic [MAX_POINTS-1:0]  seeded = '0;
    int                     seeded_list[$];
    int                     recent_points[$];
    logic signed [IO_W-1:0] rest_keep [NAX][MAX_POINTS];

    soft_body_point_step dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_opcode      (i_opcode),
        .i_point_index (i_point_index),
        .i_rest_x      (i_rest_x),
        .i_rest_y      (i_rest_y),
        .i_rest_z      (i_rest_z),
        .i_goal_weight (i_goal_weight),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_point_out   (o_point_out),
        .o_pos_x       (o_pos_x),
        .o_pos_y       (o_pos_y),
        .o_pos_z       (o_pos_z),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    soft_body_point_step_chk chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_stall    (o_stall),
        .i_opcode      (i_opcode),
        .i_point_index (i_point_index),
        .i_rest_x      (i_rest_x),
        .i_rest_y      (i_rest_y),
        .i_rest_z      (i_rest_z),
        .i_goal_weight (i_goal_weight),
        .i_out_valid   (o_valid),
        .i_out_stall   (i_stall),
        .i_point_out   (o_point_out),
        .i_pos_x       (o_pos_x),
        .i_pos_y       (o_pos_y),
        .i_pos_z       (o_pos_z),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_mismatches  (mismatches),
        .o_pending     (pending)
    );

    always #4 i_clk = ~i_clk;

    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    // result side: random stalls, or a long hold-off when one is requested
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            i_stall   <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic offer_item(t_op op, logic [IDX_W-1:0] idx, logic [IO_W-1:0] rx,
                              logic [IO_W-1:0] ry, logic [IO_W-1:0] rz,
                              logic [FIN_W-1:0] g);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_opcode      <= op;
        i_point_index <= idx;
        i_rest_x      <= rx;
        i_rest_y      <= ry;
        i_rest_z      <= rz;
        i_goal_weight <= g;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        if (op == OP_INIT) begin
            rest_keep[0][idx] = rx;
            rest_keep[1][idx] = ry;
            rest_keep[2][idx] = rz;
            if (!seeded[idx]) begin
                seeded[idx] = 1'b1;
                seeded_list.push_back(int'(idx));
            end
        end
        recent_points.push_back(int'(idx));
        if (recent_points.size() > 4) void'(recent_points.pop_front());
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [FIN_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // stop offering and wait for every outstanding result
    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        logic [IDX_W-1:0]       idx;
        logic signed [IO_W-1:0] r [NAX];
        logic [FIN_W-1:0]       g;
        logic [FIN_W-1:0]       k;
        logic [FIN_W-1:0]       d;
        int                     roll;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, saturation, goal above one, back-to-back on one point
        write_reg(CFG_STIFFNESS, 17'h04000);
        write_reg(CFG_DAMPING, 17'h01000);
        write_reg(CFG_SPARE_A, 17'h1FFFF);
        write_reg(CFG_SPARE_B, FIN_W'($urandom_range(17'h1FFFF)));
        offer_item(OP_INIT, 0, WORD_MAX, WORD_MAX, WORD_MAX, '0);
        offer_item(OP_INIT, 1023, WORD_MIN, WORD_MIN, WORD_MIN, FRAC_ONE);
        offer_item(OP_INIT, 1, '0, '0, '0, 17'h1FFFF);
        offer_item(OP_INIT, 2, 32'h0001_0000, 32'hFFFF_0000, 32'h1234_5678, 17'h08000);
        offer_item(OP_STEP, 0, WORD_MIN, WORD_MIN, WORD_MIN, '0);
        offer_item(OP_STEP, 1023, WORD_MAX, WORD_MAX, WORD_MAX, '0);
        offer_item(OP_STEP, 1, WORD_MAX, WORD_MIN, 32'h5555_5555, FRAC_ONE);
        offer_item(OP_STEP, 2, 32'hAAAA_AAAA, 32'h0000_FFFF, '0, 17'h1FFFF);
        offer_item(OP_STEP, 2, 32'h0001_0000, 32'hFFFF_0000, 32'h1234_5678, 17'h08000);
        offer_item(OP_STEP, 2, 32'h0001_0000, 32'hFFFF_0000, 32'h1234_5678, 17'h00001);
        offer_item(OP_STEP, 2, 32'h0001_0000, 32'hFFFF_0000, 32'h1234_5678, 17'h10001);
        offer_item(OP_STEP, 0, WORD_MAX, WORD_MAX, WORD_MAX, 17'h0FFFF);
        offer_item(OP_INIT, 0, 32'h0100_0000, 32'hFF00_0000, '0, '0);
        offer_item(OP_STEP, 0, '0, '0, '0, '0);
        offer_item(OP_STEP, 1023, WORD_MAX, WORD_MAX, WORD_MAX, '0);
        wait_drained();
        write_reg(CFG_STIFFNESS, 17'h1FFFF);
        write_reg(CFG_DAMPING, 17'h1FFFF);
        offer_item(OP_STEP, 0, WORD_MIN, WORD_MAX, '0, 17'h00100);
        offer_item(OP_STEP, 1, WORD_MIN, WORD_MAX, '0, '0);
        offer_item(OP_STEP, 2, WORD_MAX, WORD_MIN, 32'h0000_8000, 17'h04000);
        offer_item(OP_STEP, 1023, '0, '0, '0, '0);
        wait_drained();
        write_reg(CFG_STIFFNESS, FRAC_ONE);
        write_reg(CFG_DAMPING, '0);
        offer_item(OP_STEP, 1023, WORD_MIN, WORD_MIN, WORD_MIN, '0);
        offer_item(OP_STEP, 0, 32'h0100_0000, 32'hFF00_0000, '0, '0);

        for (int p = 0; p < NPHASES; p++) begin
            wait_drained();
            case (p)
                0: begin k = FRAC_ONE; d = FRAC_ONE; end
                1: begin k = '0; d = '0; end
                2: begin k = 17'h1FFFF; d = '0; end
                3: begin
                    k = FIN_W'($urandom_range(17'h1FFFF));
                    d = FIN_W'($urandom_range(17'h1FFFF));
                end
                4: begin k = 17'h00800; d = 17'h00400; end
                default: begin k = FIN_W'($urandom_range(FRAC_ONE)); d = 17'h1FFFF; end
            endcase
            write_reg(CFG_STIFFNESS, k);
            write_reg(CFG_DAMPING, d);
            if (p == 3) write_reg(CFG_SPARE_B, FIN_W'($urandom_range(17'h1FFFF)));
            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct <= 0;  end
                1: begin send_idle_pct = 64; stall_pct <= 0;  end
                2: begin send_idle_pct = 0;  stall_pct <= 64; end
                default: begin send_idle_pct = 20; stall_pct <= 20; end
            endcase

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // long hold-off on results while items keep coming
                if (p == 0 && n == 60) hold_req <= hold_req + 1;
                if (p == 2 && n == 128) wait_drained();
                roll = $urandom_range(99);
                if (roll < 12 || seeded_list.size() == 0) begin
                    idx = IDX_W'($urandom_range(MAX_POINTS - 1));
                    for (int a = 0; a < NAX; a++) begin
                        if (roll < 4) r[a] = $urandom;
                        else r[a] = int'($urandom_range(2 * SPAN)) - SPAN;
                    end
                    offer_item(OP_INIT, idx, r[0], r[1], r[2],
                               FIN_W'($urandom_range(17'h1FFFF)));
                end else begin
                    // revisiting recent points keeps items for one point close together
                    if (recent_points.size() != 0 && $urandom_range(1) == 1)
                        idx = IDX_W'(recent_points[$urandom_range(recent_points.size() - 1)]);
                    else
                        idx = IDX_W'(seeded_list[$urandom_range(seeded_list.size() - 1)]);
                    roll = $urandom_range(99);
                    for (int a = 0; a < NAX; a++) begin
                        if (roll < 70) r[a] = rest_keep[a][idx];
                        else if (roll < 90)
                            r[a] = rest_keep[a][idx] + (int'($urandom_range(2 * NUDGE)) - NUDGE);
                        else r[a] = $urandom;
                    end
                    case ($urandom_range(9))
                        0: g = '0;
                        1: g = FRAC_ONE;
                        2: g = FIN_W'($urandom_range(17'h1FFFF));
                        default: g = FIN_W'($urandom_range(17'h03000));
                    endcase
                    offer_item(OP_STEP, idx, r[0], r[1], r[2], g);
                end
            end
        end

        wait_drained();
        repeat (16) @(posedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
